>>> rtl/core/rdp_pkg.sv
// rowing data packet parser package: field codes, field sizes and the
// request struct passed to the field selector. no dependencies.
package rdp_pkg;

  localparam int unsigned NumFields = 13;
  localparam int unsigned CurW      = 4;
  localparam int unsigned SizeW     = 3;

  localparam logic [CurW-1:0] FldStrokeRate = 4'd0;
  localparam logic [CurW-1:0] FldDistance   = 4'd3;
  localparam logic [CurW-1:0] FldPace       = 4'd4;
  localparam logic [CurW-1:0] FldPower      = 4'd6;
  localparam logic [CurW-1:0] FldEnergy     = 4'd9;
  localparam logic [CurW-1:0] FldHeart      = 4'd10;
  localparam logic [CurW-1:0] FldElapsed    = 4'd12;
  localparam logic [CurW-1:0] NoField       = 4'd13;

  typedef struct packed {
    logic [15:0]     flags;
    logic [CurW-1:0] from;
    logic [7:0]      pos;
    logic [7:0]      len;
  } sel_req_t;

  function automatic logic [SizeW-1:0] fld_size(input logic [CurW-1:0] f);
    logic [SizeW-1:0] s;
    unique case (f)
      4'd0, 4'd2, 4'd10, 4'd11: s = 3'd1;
      4'd3:                     s = 3'd3;
      4'd9:                     s = 3'd5;
      default:                  s = 3'd2;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/rdp_field_sel.sv
// rowing data packet parser: picks the next enabled field that fits
// in the packet. depends on rdp_pkg.
module rdp_field_sel (
  input  rdp_pkg::sel_req_t         req_i,
  output logic [rdp_pkg::CurW-1:0]  field_o
);

  logic [rdp_pkg::NumFields-1:0] en;
  logic [rdp_pkg::NumFields-1:0] cand;

  // stroke rate and stroke count both follow the inverted bit 0
  assign en = {req_i.flags[11:1], !req_i.flags[0], !req_i.flags[0]};

  always_comb begin
    for (int f = 0; f < rdp_pkg::NumFields; f++) begin
      cand[f] = en[f]
                && (({1'b0, req_i.pos} + 9'(rdp_pkg::fld_size(rdp_pkg::CurW'(f))))
                    <= {1'b0, req_i.len})
                && (rdp_pkg::CurW'(f) >= req_i.from);
    end
  end

  // lowest candidate wins
  always_comb begin
    field_o = rdp_pkg::NoField;
    for (int f = rdp_pkg::NumFields - 1; f >= 0; f--) begin
      if (cand[f]) begin
        field_o = rdp_pkg::CurW'(f);
      end
    end
  end

endmodule

>>> rtl/core/rowing_data_packet_parser.sv
// rowing data packet parser top level: input register, per-word field
// decode, held values and result register. depends on rdp_pkg, rdp_field_sel.
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one packet word per
//   handshake: data_byte_i, first_byte_i marking word 0 of a packet, and
//   packet_length_i sampled with first_byte_i.
//   output channel (out_valid_o / out_ready_i) carries one record of the
//   latest held values after the last word of each packet, with parsed_o
//   low for packets shorter than two words.
//   path: a word accepted enters the input register and is decoded from
//   there; a record it completes is written into the result register as the
//   word leaves the input register, and is then valid on the output.
//   throughput: one word per cycle unless a record is blocked; a word's decode
//   is a single pass of flag, size and length compares feeding the state registers.
//   reset clears all held values, the flags, the position and length, and
//   leaves both registers empty.
//   when the receiver stalls with a record waiting, words that complete no
//   packet keep flowing; a word that ends a packet waits in the input
//   register, and ready drops once that register is occupied and blocked.
module rowing_data_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [7:0]  packet_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  stroke_rate_o,
  output logic [23:0] total_distance_o,
  output logic [15:0] inst_pace_o,
  output logic [15:0] inst_power_o,
  output logic [15:0] total_energy_o,
  output logic [7:0]  heart_bpm_o,
  output logic [15:0] elapsed_seconds_o,
  output logic        parsed_o
);

  localparam int unsigned CurW = rdp_pkg::CurW;

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic [7:0] plen_q;

  // parser state
  logic [15:0]     flags_q, flags_d;
  logic [7:0]      pos_q, pos_d;
  logic [7:0]      latch_q, latch_d;
  logic [CurW-1:0] cur_q, cur_d;
  logic [23:0]     asm_q, asm_d;
  logic [2:0]      off_q, off_d;

  logic [7:0]  rate_q, rate_d;
  logic [23:0] dist_q, dist_d;
  logic [15:0] pace_q, pace_d;
  logic [15:0] power_q, power_d;
  logic [15:0] energy_q, energy_d;
  logic [7:0]  heart_q, heart_d;
  logic [15:0] elapsed_q, elapsed_d;

  // result register
  logic        out_vld_q;
  logic [7:0]  o_rate_q;
  logic [23:0] o_dist_q;
  logic [15:0] o_pace_q, o_power_q, o_energy_q, o_elapsed_q;
  logic [7:0]  o_heart_q;
  logic        o_parsed_q;

  logic       ignore, emit, advance, step;
  logic [7:0] len, p;
  logic [23:0] asm_new;
  logic        fld_done;
  rdp_pkg::sel_req_t sel_req;
  logic [CurW-1:0]   sel_field;

  assign len     = first_q ? plen_q : latch_q;
  assign p       = first_q ? 8'd0 : pos_q;
  assign ignore  = !first_q && (latch_q == 8'd0);
  assign emit    = !ignore && (({1'b0, p} + 9'd1) >= {1'b0, len});
  assign advance = !emit || !out_vld_q || out_ready_i;
  assign step    = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    flags_d = flags_q;
    if (p == 8'd0) begin
      flags_d = {8'h00, byte_q};
    end else if (p == 8'd1) begin
      flags_d = {byte_q, flags_q[7:0]};
    end
  end

  assign sel_req.flags = flags_d;
  assign sel_req.from  = (p == 8'd1) ? '0 : cur_q + CurW'(1);
  assign sel_req.pos   = (p == 8'd1) ? 8'd2 : p + 8'd1;
  assign sel_req.len   = len;

  rdp_field_sel u_sel (
    .req_i   (sel_req),
    .field_o (sel_field)
  );

  assign asm_new  = (off_q < 3'd3) ? (asm_q | (24'(byte_q) << {off_q[1:0], 3'b000})) : asm_q;
  assign fld_done = ({1'b0, off_q} + 4'd1) >= {1'b0, rdp_pkg::fld_size(cur_q)};

  always_comb begin
    cur_d     = cur_q;
    asm_d     = asm_q;
    off_d     = off_q;
    rate_d    = rate_q;
    dist_d    = dist_q;
    pace_d    = pace_q;
    power_d   = power_q;
    energy_d  = energy_q;
    heart_d   = heart_q;
    elapsed_d = elapsed_q;
    if (p == 8'd0) begin
      cur_d = rdp_pkg::NoField;
      asm_d = '0;
      off_d = '0;
    end else if (p == 8'd1) begin
      cur_d = sel_field;
      asm_d = '0;
      off_d = '0;
    end else if (cur_q < rdp_pkg::NoField) begin
      asm_d = asm_new;
      if (fld_done) begin
        unique case (cur_q)
          rdp_pkg::FldStrokeRate: rate_d    = asm_new[7:0];
          rdp_pkg::FldDistance:   dist_d    = asm_new;
          rdp_pkg::FldPace:       pace_d    = asm_new[15:0];
          rdp_pkg::FldPower:      power_d   = asm_new[15:0];
          rdp_pkg::FldEnergy:     energy_d  = asm_new[15:0];
          rdp_pkg::FldHeart:      heart_d   = asm_new[7:0];
          rdp_pkg::FldElapsed:    elapsed_d = asm_new[15:0];
          default: begin
          end
        endcase
        cur_d = sel_field;
        asm_d = '0;
        off_d = '0;
      end else begin
        off_d = off_q + 3'd1;
      end
    end
  end

  assign latch_d = emit ? 8'd0 : len;
  assign pos_d   = emit ? 8'd0 : p + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      byte_q   <= '0;
      first_q  <= 1'b0;
      plen_q   <= '0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
      byte_q   <= data_byte_i;
      first_q  <= first_byte_i;
      plen_q   <= packet_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      pos_q     <= '0;
      latch_q   <= '0;
      cur_q     <= '0;
      asm_q     <= '0;
      off_q     <= '0;
      rate_q    <= '0;
      dist_q    <= '0;
      pace_q    <= '0;
      power_q   <= '0;
      energy_q  <= '0;
      heart_q   <= '0;
      elapsed_q <= '0;
    end else if (step && !ignore) begin
      flags_q   <= flags_d;
      pos_q     <= pos_d;
      latch_q   <= latch_d;
      cur_q     <= cur_d;
      asm_q     <= asm_d;
      off_q     <= off_d;
      rate_q    <= rate_d;
      dist_q    <= dist_d;
      pace_q    <= pace_d;
      power_q   <= power_d;
      energy_q  <= energy_d;
      heart_q   <= heart_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      o_rate_q    <= rate_d;
      o_dist_q    <= dist_d;
      o_pace_q    <= pace_d;
      o_power_q   <= power_d;
      o_energy_q  <= energy_d;
      o_heart_q   <= heart_d;
      o_elapsed_q <= elapsed_d;
      o_parsed_q  <= (len >= 8'd2);
    end
  end

  assign out_valid_o       = out_vld_q;
  assign stroke_rate_o     = o_rate_q;
  assign total_distance_o  = o_dist_q;
  assign inst_pace_o       = o_pace_q;
  assign inst_power_o      = o_power_q;
  assign total_energy_o    = o_energy_q;
  assign heart_bpm_o       = o_heart_q;
  assign elapsed_seconds_o = o_elapsed_q;
  assign parsed_o          = o_parsed_q;

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= rdp_pkg::NoField)
    else $error("field cursor out of range");

  a_off_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q < rdp_pkg::NoField) |-> (off_q < rdp_pkg::fld_size(cur_q)))
    else $error("field offset beyond field size");

  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (latch_q == 8'd0) |-> (pos_q == 8'd0))
    else $error("position set with no packet in progress");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_vld_q && !out_ready_i && emit))
    else $error("input stalled without a blocked record");

  a_emit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit) |=> out_vld_q)
    else $error("record lost");

endmodule

>>> verif/rowing_data_packet_parser_tb.sv
`timescale 1ns / 1ps
// testbench for rowing_data_packet_parser: directed table, then random packets
// checked against a local packet decoder. depends on rdp_pkg and the parser rtl.

module rowing_data_packet_parser_tb;

  localparam int NUM_DIR     = 23;
  localparam int NUM_WORDS   = 600;
  localparam int QUIET_WORDS = 520;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [7:0]  stroke_rate;
    logic [23:0] distance;
    logic [15:0] pace;
    logic [15:0] power;
    logic [15:0] energy;
    logic [7:0]  heart;
    logic [15:0] elapsed;
    logic        parsed;
  } rec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic [7:0] plen;
    logic       typed;
    rec_t       rec;
  } stim_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i     = 8'h00;
  logic        first_byte_i    = 1'b0;
  logic [7:0]  packet_length_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [7:0]  stroke_rate_o;
  logic [23:0] total_distance_o;
  logic [15:0] inst_pace_o;
  logic [15:0] inst_power_o;
  logic [15:0] total_energy_o;
  logic [7:0]  heart_bpm_o;
  logic [15:0] elapsed_seconds_o;
  logic        parsed_o;

  rowing_data_packet_parser DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .first_byte_i      (first_byte_i),
    .packet_length_i   (packet_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .stroke_rate_o     (stroke_rate_o),
    .total_distance_o  (total_distance_o),
    .inst_pace_o       (inst_pace_o),
    .inst_power_o      (inst_power_o),
    .total_energy_o    (total_energy_o),
    .heart_bpm_o       (heart_bpm_o),
    .elapsed_seconds_o (elapsed_seconds_o),
    .parsed_o          (parsed_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // decoder state
  logic [7:0]  h_rate;
  logic [23:0] h_dist;
  logic [15:0] h_pace;
  logic [15:0] h_power;
  logic [15:0] h_energy;
  logic [7:0]  h_heart;
  logic [15:0] h_elapsed;
  logic [15:0] flags;
  logic [7:0]  pos;
  logic [7:0]  len_latch;
  logic [3:0]  cursor;
  logic [23:0] asm_bytes;
  logic [2:0]  offset;

  rec_t record_q [$];
  int   mismatches = 0;
  int   cycles     = 0;
  int   stall_left = 0;
  bit   quiet      = 1'b0;

  function automatic int field_bytes(input int f);
    int n;
    case (f)
      1, 4, 5, 6, 7, 8, 12: n = 2;
      3:                    n = 3;
      9:                    n = 5;
      default:              n = 1;
    endcase
    return n;
  endfunction

  function automatic bit field_on(input int f, input logic [15:0] fl);
    if (f < 2) return !fl[0];
    return fl[f-1];
  endfunction

  function automatic logic [3:0] next_field_at(input int from, input int p, input int l);
    for (int f = from; f < int'(rdp_pkg::NoField); f++) begin
      if (field_on(f, flags) && (p + field_bytes(f) <= l)) return 4'(f);
    end
    return rdp_pkg::NoField;
  endfunction

  task automatic decode_word(input logic [7:0] b, input logic first, input logic [7:0] plen,
                             output bit emit, output rec_t r);
    int l;
    int p;
    emit = 1'b0;
    r    = '0;
    if (first) begin
      l = plen;
      p = 0;
    end else begin
      if (len_latch == 8'd0) return;
      l = len_latch;
      p = pos;
    end
    if (p == 0) begin
      flags     = {8'h00, b};
      cursor    = rdp_pkg::NoField;
      asm_bytes = '0;
      offset    = '0;
    end else if (p == 1) begin
      flags[15:8] = b;
      cursor      = next_field_at(0, 2, l);
      asm_bytes   = '0;
      offset      = '0;
    end else if (cursor < rdp_pkg::NoField) begin
      if (offset < 3) asm_bytes = asm_bytes | (24'(b) << (8 * offset));
      if (int'(offset) + 1 >= field_bytes(cursor)) begin
        case (cursor)
          rdp_pkg::FldStrokeRate: h_rate    = asm_bytes[7:0];
          rdp_pkg::FldDistance:   h_dist    = asm_bytes;
          rdp_pkg::FldPace:       h_pace    = asm_bytes[15:0];
          rdp_pkg::FldPower:      h_power   = asm_bytes[15:0];
          rdp_pkg::FldEnergy:     h_energy  = asm_bytes[15:0];
          rdp_pkg::FldHeart:      h_heart   = asm_bytes[7:0];
          rdp_pkg::FldElapsed:    h_elapsed = asm_bytes[15:0];
          default: ;
        endcase
        cursor    = next_field_at(int'(cursor) + 1, p + 1, l);
        asm_bytes = '0;
        offset    = '0;
      end else begin
        offset = offset + 3'd1;
      end
    end
    if (p + 1 >= l) begin
      emit      = 1'b1;
      r         = '{h_rate, h_dist, h_pace, h_power, h_energy, h_heart, h_elapsed, l >= 2};
      len_latch = '0;
      pos       = '0;
    end else begin
      len_latch = 8'(l);
      pos       = 8'(p + 1);
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic first, input logic [7:0] plen,
                           input bit typed, input rec_t want);
    bit   emit;
    rec_t pred;
    if (!quiet && ($urandom_range(0, 5) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    first_byte_i    <= first;
    packet_length_i <= plen;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_word(b, first, plen, emit, pred);
    if (emit) record_q.push_back(typed ? want : pred);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 11);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rec_t got;
    rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{stroke_rate_o, total_distance_o, inst_pace_o, inst_power_o, total_energy_o,
              heart_bpm_o, elapsed_seconds_o, parsed_o};
      if (record_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected record: %p", got);
        mismatches++;
      end else begin
        want = record_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("record mismatch at cycle %0d", cycles);
            $display("  expected rate %h dist %h pace %h power %h energy %h hr %h time %h ok %b",
                     want.stroke_rate, want.distance, want.pace, want.power, want.energy,
                     want.heart, want.elapsed, want.parsed);
            $display("  actual   rate %h dist %h pace %h power %h energy %h hr %h time %h ok %b",
                     got.stroke_rate, got.distance, got.pace, got.power, got.energy,
                     got.heart, got.elapsed, got.parsed);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   dir_tab [NUM_DIR];
    int          words_sent;
    int          len;
    int          nat;
    int          n;
    int          kind;
    logic [15:0] fl;
    logic [7:0]  b;

    h_rate = '0; h_dist = '0; h_pace = '0; h_power = '0; h_energy = '0;
    h_heart = '0; h_elapsed = '0; flags = '0; pos = '0; len_latch = '0;
    cursor = '0; asm_bytes = '0; offset = '0;
    words_sent = 0;

    dir_tab = '{
      // one-word and zero-length packets right after reset
      '{8'h00, 1'b1, 8'd1,   1'b1, '0},
      '{8'hFF, 1'b1, 8'd0,   1'b1, '0},
      // stray word with no packet open
      '{8'h5A, 1'b0, 8'd7,   1'b0, '0},
      // stroke data only, max values
      '{8'h00, 1'b1, 8'd5,   1'b0, '0},
      '{8'h00, 1'b0, 8'hAA,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h55,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'hFF,  1'b0, '0},
      // distance, power and elapsed time, no stroke data
      '{8'h25, 1'b1, 8'd9,   1'b0, '0},
      '{8'h08, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00,  1'b0, '0},
      // longest packet abandoned by a restart
      '{8'h01, 1'b1, 8'd255, 1'b0, '0},
      // pace, energy that does not fit, heart rate
      '{8'h09, 1'b1, 8'd5,   1'b0, '0},
      '{8'h03, 1'b0, 8'h00,  1'b0, '0},
      '{8'h34, 1'b0, 8'h00,  1'b0, '0},
      '{8'h12, 1'b0, 8'h00,  1'b0, '0},
      '{8'h77, 1'b0, 8'h00,  1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++)
      send_word(dir_tab[i].data, dir_tab[i].first, dir_tab[i].plen, dir_tab[i].typed,
                dir_tab[i].rec);

    while (words_sent < NUM_WORDS) begin
      if (words_sent >= QUIET_WORDS) quiet = 1'b1;
      if (($urandom_range(0, 19) == 0) && (len_latch == 8'd0)) begin
        repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, 8'($urandom), 1'b0, '0);
      end
      fl  = 16'($urandom);
      nat = 2;
      for (int f = 0; f < int'(rdp_pkg::NoField); f++)
        if (field_on(f, fl)) nat += field_bytes(f);
      kind = $urandom_range(0, 99);
      if (kind < 4) len = $urandom_range(0, 2);
      else if (kind < 6) len = 255;
      else len = nat + int'($urandom_range(0, 5)) - 3;
      if (len < 0) len = 0;
      if (len > 255) len = 255;
      n = (len == 0) ? 1 : len;
      // broken packet: cut short, the next first word restarts
      if ((kind >= 6) && (kind < 15) && (n > 1)) n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) begin
        if (i == 0) begin
          send_word(fl[7:0], 1'b1, 8'(len), 1'b0, '0);
        end else begin
          case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
          endcase
          if (i == 1) b = fl[15:8];
          send_word(b, 1'b0, 8'($urandom), 1'b0, '0);
        end
        words_sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (record_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if ((mismatches == 0) && (record_q.size() == 0)) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
